FILE: rtl/wmrf_pkg.sv
package wmrf_pkg;

    // window geometry defaults
    localparam int WIN_ROWS_DEF = 3;
    localparam int WIN_COLS_DEF = 3;

    // datapath widths
    localparam int PIX_W      = 8;
    localparam int RECIP_FRAC = 24;
    localparam int RECIP_W    = RECIP_FRAC + 1;
    localparam int NUM_W      = 36;
    localparam int DEN_W      = 28;
    localparam int PROD_W     = 72;
    localparam int QUO_W      = 8;
    localparam int TAB_DEPTH  = 1 << PIX_W;

    // filter selection codes
    typedef enum logic [2:0] {
        MODE_MEAN   = 3'd0,
        MODE_GEO    = 3'd1,
        MODE_HARM   = 3'd2,
        MODE_CONTRA = 3'd3,
        MODE_MEDIAN = 3'd4,
        MODE_MAX    = 3'd5,
        MODE_MIN    = 3'd6,
        MODE_MID    = 3'd7
    } wmrf_mode_t;

    // configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_ORDER = 1'b1;

    typedef logic [RECIP_W-1:0] recip_tab_t [TAB_DEPTH];
    typedef logic [PROD_W-1:0]  pow9_tab_t  [TAB_DEPTH];

    // floor(2^24 / p) by shift and subtract, zero for p = 0
    function automatic recip_tab_t make_recip();
        recip_tab_t         t;
        logic [RECIP_W:0]   r;
        logic [RECIP_W-1:0] q;
        for (int p = 0; p < TAB_DEPTH; p++)
        begin
            r = '0;
            q = '0;
            for (int b = RECIP_W - 1; b >= 0; b--)
            begin
                r = {r[RECIP_W-1:0], (b == RECIP_FRAC)};
                if (p != 0 && r >= (RECIP_W + 1)'(p))
                begin
                    r    = r - (RECIP_W + 1)'(p);
                    q[b] = 1'b1;
                end
            end
            t[p] = q;
        end
        return t;
    endfunction

    // c^9 for every 8-bit c
    function automatic pow9_tab_t make_pow9();
        pow9_tab_t         t;
        logic [PROD_W-1:0] v;
        for (int c = 0; c < TAB_DEPTH; c++)
        begin
            v = PROD_W'(1);
            for (int k = 0; k < 9; k++)
            begin
                v = v * PROD_W'(c);
            end
            t[c] = v;
        end
        return t;
    endfunction

    localparam recip_tab_t RECIP_TAB = make_recip();
    localparam pow9_tab_t  POW9_TAB  = make_pow9();

    // one item inside the bit-serial divide and root unit
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
        logic [PROD_W-1:0] prod;
        logic [PIX_W-1:0]  root;
        logic              sat;
        logic              zero;
        logic [PIX_W-1:0]  simple;
    } wmrf_iter_t;

endpackage

FILE: rtl/wmrf_iter.sv
module wmrf_iter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wmrf_pkg::wmrf_iter_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wmrf_pkg::wmrf_iter_t out_data
);

    localparam int STEPS = wmrf_pkg::QUO_W;

    logic [STEPS-1:0]      v_reg;
    wmrf_pkg::wmrf_iter_t  d_reg  [STEPS];
    wmrf_pkg::wmrf_iter_t  d_next [STEPS];
    wmrf_pkg::wmrf_iter_t  src    [STEPS];
    logic [wmrf_pkg::NUM_W-1:0] dsh  [STEPS];
    logic [wmrf_pkg::PIX_W-1:0] cand [STEPS];
    logic [STEPS:0]        en;
    logic [STEPS-1:0]      v_src;

    // stall chain, a stage moves when it is empty or its successor moves
    always_comb
    begin
        en[STEPS] = out_ready;
        for (int k = STEPS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_src = {v_reg[STEPS-2:0], in_valid};

    // one quotient bit and one root bit per stage, msb first
    always_comb
    begin
        src[0] = in_data;
        for (int k = 1; k < STEPS; k++)
        begin
            src[k] = d_reg[k-1];
        end
        for (int k = 0; k < STEPS; k++)
        begin
            d_next[k] = src[k];
            dsh[k]    = wmrf_pkg::NUM_W'(src[k].den) << (STEPS - 1 - k);
            if (src[k].rem >= dsh[k])
            begin
                d_next[k].rem                = src[k].rem - dsh[k];
                d_next[k].quo[STEPS - 1 - k] = 1'b1;
            end
            cand[k] = src[k].root | (wmrf_pkg::PIX_W'(1) << (STEPS - 1 - k));
            if (wmrf_pkg::POW9_TAB[cand[k]] <= src[k].prod)
            begin
                d_next[k].root = cand[k];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_src[k];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (en[k])
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STEPS-1];
    assign out_data  = d_reg[STEPS-1];

endmodule

FILE: rtl/window_mean_and_rank_filter.sv
// throughput: one window per cycle; five front stages, eight bit-serial
// divide and ninth-root stages (one quotient bit and one root bit each),
// one output register; a stalled output only halts stages that are full
// reset: rst_n clears all valid bits, filter_mode and contra_order
module window_mean_and_rank_filter
#(
    parameter int WIN_ROWS = wmrf_pkg::WIN_ROWS_DEF,
    parameter int WIN_COLS = wmrf_pkg::WIN_COLS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // pix_0 .. pix_8, 8 bits each, pix_0 in the lowest bits
    input  logic [wmrf_pkg::PIX_W*WIN_ROWS*WIN_COLS-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // filtered_pixel
    output logic [wmrf_pkg::PIX_W-1:0] m_tdata,
    input  logic       cfg_we,
    input  logic [0:0] cfg_idx,
    input  logic [2:0] cfg_data
);

    localparam int NPIX       = WIN_ROWS * WIN_COLS;
    localparam int PW         = wmrf_pkg::PIX_W;
    localparam int RANK_W     = $clog2(NPIX);
    localparam int MED_RANK   = (NPIX - 1) / 2;
    localparam int MAX_RANK   = NPIX - 1;
    localparam int SUM_W      = PW + $clog2(NPIX);
    localparam int MEAN_SHIFT = 16;
    localparam int MEAN_MUL   = ((1 << MEAN_SHIFT) + NPIX - 1) / NPIX;
    localparam int MEAN_W     = SUM_W + MEAN_SHIFT;
    localparam int NUM_W      = wmrf_pkg::NUM_W;
    localparam int DEN_W      = wmrf_pkg::DEN_W;
    localparam int RW         = wmrf_pkg::RECIP_W;
    localparam logic [NUM_W-1:0] HARM_NUM = NUM_W'(NPIX) << wmrf_pkg::RECIP_FRAC;

    // configuration
    wmrf_pkg::wmrf_mode_t mode_reg;
    logic [1:0]           order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= wmrf_pkg::MODE_MEAN;
            order_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                wmrf_pkg::REG_MODE:  mode_reg  <= wmrf_pkg::wmrf_mode_t'(cfg_data);
                wmrf_pkg::REG_ORDER: order_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_tvalid_reg;
    logic en1, en2, en3, en4, en5, out_en;
    logic iter_in_ready, iter_out_valid;
    wmrf_pkg::wmrf_iter_t it5_reg, it5_next, iter_out;

    assign out_en   = !m_tvalid_reg || m_tready;
    assign en5      = !v5_reg || iter_in_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (en1)    v1_reg       <= s_tvalid;
            if (en2)    v2_reg       <= v1_reg;
            if (en3)    v3_reg       <= v2_reg;
            if (en4)    v4_reg       <= v3_reg;
            if (en5)    v5_reg       <= v4_reg;
            if (out_en) m_tvalid_reg <= iter_out_valid;
        end
    end

    // stage 1: unpack, squares, reciprocals, rank compares, pair products
    logic [PW-1:0]     px_in    [NPIX];
    logic [PW-1:0]     px1_reg  [NPIX];
    logic [2*PW-1:0]   sq1_reg  [NPIX];
    logic [RW-1:0]     rec1_reg [NPIX];
    logic [NPIX-1:0]   lt1_reg  [NPIX];
    logic [NPIX-1:0]   lt_next  [NPIX];
    logic [2*PW-1:0]   gp1_reg  [4];
    logic              zero_next, zero1_reg;

    always_comb
    begin
        zero_next = 1'b0;
        for (int i = 0; i < NPIX; i++)
        begin
            px_in[i]  = s_tdata[PW*i +: PW];
            zero_next = zero_next || (px_in[i] == '0);
        end
        for (int i = 0; i < NPIX; i++)
        begin
            for (int j = 0; j < NPIX; j++)
            begin
                lt_next[i][j] = (j != i) && ((px_in[j] < px_in[i]) ||
                                ((px_in[j] == px_in[i]) && (j < i)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < NPIX; i++)
            begin
                px1_reg[i]  <= px_in[i];
                sq1_reg[i]  <= (2*PW)'(px_in[i]) * (2*PW)'(px_in[i]);
                rec1_reg[i] <= wmrf_pkg::RECIP_TAB[px_in[i]];
                lt1_reg[i]  <= lt_next[i];
            end
            for (int k = 0; k < 4; k++)
            begin
                gp1_reg[k] <= (2*PW)'(px_in[2*k]) * (2*PW)'(px_in[2*k+1]);
            end
            zero1_reg <= zero_next;
        end
    end

    // stage 2: ranks, cubes and fourth powers, partial sums, geometric tree
    logic [PW-1:0]     px2_reg   [NPIX];
    logic [2*PW-1:0]   sq2_reg   [NPIX];
    logic [3*PW-1:0]   cube2_reg [NPIX];
    logic [4*PW-1:0]   quad2_reg [NPIX];
    logic [RANK_W-1:0] rank_next [NPIX];
    logic [RANK_W-1:0] rank2_reg [NPIX];
    logic [RW+1:0]     hp_next   [3];
    logic [RW+1:0]     hp2_reg   [3];
    logic [4*PW-1:0]   g2_reg    [2];
    logic [SUM_W-1:0]  sum_next, sum2_reg;
    logic              zero2_reg;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NPIX; i++)
        begin
            rank_next[i] = '0;
            for (int j = 0; j < NPIX; j++)
            begin
                rank_next[i] = rank_next[i] + RANK_W'(lt1_reg[i][j]);
            end
            sum_next = sum_next + SUM_W'(px1_reg[i]);
        end
        for (int g = 0; g < 3; g++)
        begin
            hp_next[g] = (RW + 2)'(rec1_reg[3*g]) + (RW + 2)'(rec1_reg[3*g+1]) +
                         (RW + 2)'(rec1_reg[3*g+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < NPIX; i++)
            begin
                px2_reg[i]   <= px1_reg[i];
                sq2_reg[i]   <= sq1_reg[i];
                cube2_reg[i] <= (3*PW)'(sq1_reg[i]) * (3*PW)'(px1_reg[i]);
                quad2_reg[i] <= (4*PW)'(sq1_reg[i]) * (4*PW)'(sq1_reg[i]);
                rank2_reg[i] <= rank_next[i];
            end
            for (int g = 0; g < 3; g++)
            begin
                hp2_reg[g] <= hp_next[g];
            end
            g2_reg[0] <= (4*PW)'(gp1_reg[0]) * (4*PW)'(gp1_reg[1]);
            g2_reg[1] <= (4*PW)'(gp1_reg[2]) * (4*PW)'(gp1_reg[3]);
            sum2_reg  <= sum_next;
            zero2_reg <= zero1_reg;
        end
    end

    // stage 3: order statistics, mean, contraharmonic terms, geometric tree
    logic [PW-1:0]     med_next, max_next, min_next;
    logic [PW-1:0]     med3_reg, max3_reg, min3_reg, mean3_reg, p8_3_reg;
    logic [DEN_W-1:0]  hsum3_reg;
    logic [NUM_W-1:0]  nt        [NPIX];
    logic [DEN_W-1:0]  dt        [NPIX];
    logic [NUM_W-1:0]  np_next   [3];
    logic [DEN_W-1:0]  dp_next   [3];
    logic [NUM_W-1:0]  np3_reg   [3];
    logic [DEN_W-1:0]  dp3_reg   [3];
    logic [8*PW-1:0]   g3_reg;
    logic [MEAN_W-1:0] mean_prod;
    logic              zero3_reg;

    always_comb
    begin
        med_next = '0;
        max_next = '0;
        min_next = '0;
        for (int i = 0; i < NPIX; i++)
        begin
            if (rank2_reg[i] == RANK_W'(MED_RANK)) med_next = med_next | px2_reg[i];
            if (rank2_reg[i] == RANK_W'(MAX_RANK)) max_next = max_next | px2_reg[i];
            if (rank2_reg[i] == '0)                min_next = min_next | px2_reg[i];
        end
        // p^Q for the denominator, p^(Q+1) for the numerator
        for (int i = 0; i < NPIX; i++)
        begin
            case (order_reg)
                2'd0:
                begin
                    dt[i] = DEN_W'(1);
                    nt[i] = NUM_W'(px2_reg[i]);
                end
                2'd1:
                begin
                    dt[i] = DEN_W'(px2_reg[i]);
                    nt[i] = NUM_W'(sq2_reg[i]);
                end
                2'd2:
                begin
                    dt[i] = DEN_W'(sq2_reg[i]);
                    nt[i] = NUM_W'(cube2_reg[i]);
                end
                default:
                begin
                    dt[i] = DEN_W'(cube2_reg[i]);
                    nt[i] = NUM_W'(quad2_reg[i]);
                end
            endcase
        end
        for (int g = 0; g < 3; g++)
        begin
            np_next[g] = nt[3*g] + nt[3*g+1] + nt[3*g+2];
            dp_next[g] = dt[3*g] + dt[3*g+1] + dt[3*g+2];
        end
        mean_prod = MEAN_W'(sum2_reg) * MEAN_W'(MEAN_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            med3_reg  <= med_next;
            max3_reg  <= max_next;
            min3_reg  <= min_next;
            mean3_reg <= mean_prod[MEAN_SHIFT +: PW];
            hsum3_reg <= DEN_W'(hp2_reg[0]) + DEN_W'(hp2_reg[1]) + DEN_W'(hp2_reg[2]);
            for (int g = 0; g < 3; g++)
            begin
                np3_reg[g] <= np_next[g];
                dp3_reg[g] <= dp_next[g];
            end
            g3_reg    <= (8*PW)'(g2_reg[0]) * (8*PW)'(g2_reg[1]);
            p8_3_reg  <= px2_reg[NPIX-1];
            zero3_reg <= zero2_reg;
        end
    end

    // stage 4: simple results, totals, full product
    logic [PW-1:0]     simple_next, simple4_reg;
    logic [PW:0]       mid_sum;
    logic [DEN_W-1:0]  hsum4_reg, den4_reg;
    logic [NUM_W-1:0]  num4_reg;
    logic [wmrf_pkg::PROD_W-1:0] prod4_reg;
    logic              zero4_reg;

    always_comb
    begin
        mid_sum = (PW + 1)'(max3_reg) + (PW + 1)'(min3_reg);
        case (mode_reg)
            wmrf_pkg::MODE_MEAN:   simple_next = mean3_reg;
            wmrf_pkg::MODE_MEDIAN: simple_next = med3_reg;
            wmrf_pkg::MODE_MAX:    simple_next = max3_reg;
            wmrf_pkg::MODE_MIN:    simple_next = min3_reg;
            wmrf_pkg::MODE_MID:    simple_next = mid_sum[PW:1];
            default:               simple_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            simple4_reg <= simple_next;
            hsum4_reg   <= hsum3_reg;
            num4_reg    <= np3_reg[0] + np3_reg[1] + np3_reg[2];
            den4_reg    <= dp3_reg[0] + dp3_reg[1] + dp3_reg[2];
            prod4_reg   <= wmrf_pkg::PROD_W'(g3_reg) * wmrf_pkg::PROD_W'(p8_3_reg);
            zero4_reg   <= zero3_reg;
        end
    end

    // stage 5: pick the division operands, overflow check
    logic [NUM_W-1:0] div_n;
    logic [DEN_W-1:0] div_d;
    logic             div_z;

    always_comb
    begin
        case (mode_reg)
            wmrf_pkg::MODE_HARM:
            begin
                div_n = HARM_NUM;
                div_d = hsum4_reg;
                div_z = zero4_reg;
            end
            wmrf_pkg::MODE_CONTRA:
            begin
                div_n = num4_reg;
                div_d = den4_reg;
                div_z = (den4_reg == '0);
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
                div_z = 1'b0;
            end
        endcase
        it5_next.rem    = div_n;
        it5_next.den    = div_d;
        it5_next.quo    = '0;
        it5_next.prod   = prod4_reg;
        it5_next.root   = '0;
        it5_next.sat    = (div_n >= {div_d, {wmrf_pkg::QUO_W{1'b0}}});
        it5_next.zero   = div_z;
        it5_next.simple = simple4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            it5_reg <= it5_next;
        end
    end

    // stages 6 to 13: bit-serial divide and ninth root
    wmrf_iter u_iter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_ready  (iter_in_ready),
        .in_data   (it5_reg),
        .out_valid (iter_out_valid),
        .out_ready (out_en),
        .out_data  (iter_out)
    );

    // output register
    logic [PW-1:0] res_next, m_tdata_reg;

    always_comb
    begin
        case (mode_reg)
            wmrf_pkg::MODE_GEO:
                res_next = iter_out.root;
            wmrf_pkg::MODE_HARM, wmrf_pkg::MODE_CONTRA:
                res_next = iter_out.zero ? '0 : (iter_out.sat ? '1 : iter_out.quo);
            default:
                res_next = iter_out.simple;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            m_tdata_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/wmrf_checker.sv
module wmrf_props
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a held output beat keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // input side only stalls when a finished beat waits at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind window_mean_and_rank_filter wmrf_props u_wmrf_props (.*);
